### design/mcpl_pkg.sv
// Shared types, codes and reset values for the motor current PI loop.
// Used by mcpl_mul and motor_current_pi_loop_core; no dependencies.
`timescale 1ns / 1ps

package mcpl_pkg;

	localparam int unsigned PERIOD_CLOCKS_DEF = 4096;

	// request kinds
	localparam logic [2:0] REQ_ARM      = 3'd0;
	localparam logic [2:0] REQ_DISARM   = 3'd1;
	localparam logic [2:0] REQ_MEAS     = 3'd2;
	localparam logic [2:0] REQ_SETPOINT = 3'd3;
	localparam logic [2:0] REQ_TICK     = 3'd4;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_MAX_MOD     = 3'd2;
	localparam logic [2:0] REG_CURR_LIMIT  = 3'd3;
	localparam logic [2:0] REG_INV_TORQUE  = 3'd4;

	localparam logic [30:0] PROP_GAIN_RST  = 31'd65536;
	localparam logic [30:0] INTEG_GAIN_RST = 31'd655;
	localparam logic [15:0] MAX_MOD_RST    = 16'd31130;
	localparam logic [30:0] CURR_LIMIT_RST = 31'd655360;
	localparam logic [30:0] INV_TORQUE_RST = 31'd65536;

	localparam logic [2:0] FAULT_TORQUE = 3'b001;
	localparam logic [2:0] FAULT_VEL    = 3'b010;
	localparam logic [2:0] FAULT_CURR   = 3'b100;

	localparam logic [15:0] FULL_Q15 = 16'd32768;

	localparam int OP_W   = 33;
	localparam int PROD_W = 2 * OP_W;
	localparam int SAT_W  = 52;

	localparam logic signed [OP_W-1:0] DECAY_Q16 = 33'sd58982;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SP_MUL,
		ST_SP,
		ST_ERR,
		ST_P_MUL,
		ST_MOD,
		ST_I_MUL,
		ST_INT,
		ST_W_MUL,
		ST_PWM,
		ST_FIN
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-32){1'b0}}, 32'h7FFF_FFFF});
		lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

### design/mcpl_mul.sv
// Shared signed multiplier with registered product.
// Depends on mcpl_pkg for operand widths.
`timescale 1ns / 1ps

module mcpl_mul
	import mcpl_pkg::*;
(
	input  logic                     clk,
	input  logic signed [OP_W-1:0]   op_a,
	input  logic signed [OP_W-1:0]   op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

### design/motor_current_pi_loop_core.sv
// Motor current PI loop: request sequencer around one shared multiplier.
// Depends on mcpl_pkg and mcpl_mul.
// Usage:
//   Request words arrive on s_axis; tuser carries the request kind, tdata the
//   measurement and torque fields. One result word per request leaves on
//   m_axis. Registers are written on the cfg channel (always ready); the user
//   must write them only while no request is in flight (not enforced).
//   s_axis_tready is high only in idle; one request is worked at a time.
//   The sequencer steps the single multiplier for each request:
//     arm, disarm, measurement, unknown kind, a setpoint update or pwm tick
//       that is ignored or faults: no multiply
//     applied setpoint update: one multiply
//     pwm tick: three multiplies, or two when the modulation goes negative,
//       each followed by its post-processing step
//   A finished word sits in the output register; the next request is taken
//   while it waits. If the receiver still stalls when the following result is
//   ready, the sequencer holds in its final step until the register frees.
//   Reset clears the loop state and loads the default gains and limits.
`timescale 1ns / 1ps

module motor_current_pi_loop_core
	import mcpl_pkg::*;
#(
	parameter int unsigned PERIOD_CLOCKS = PERIOD_CLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// current_value[31:0], current_valid[32], torque_value[64:33],
	// torque_valid[65], velocity_valid[66], zero pad
	input  logic [71:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pwm_compare[15:0], dir_forward[16], output_enable[17],
	// error_flags[20:18], zero pad
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [30:0] prop_gain_q, integ_gain_q, curr_limit_q, inv_torque_q;
	logic [15:0] max_mod_q;

	logic              armed_q, meas_valid_q, dir_now_q, dir_last_q;
	logic signed [31:0] meas_q, sp_q, integ_q;
	logic [2:0]        fault_q;

	logic [2:0]         req_type_q;
	logic signed [31:0] req_cur_q, req_torque_q;
	logic               req_cv_q, req_tv_q, req_vv_q;

	logic signed [31:0] err_q, mod_q;
	logic               clamp_hi_q;
	logic [15:0]        pwm_q;

	logic        m_valid_q;
	logic [15:0] m_pwm_q;
	logic        m_dir_q, m_en_q;
	logic [2:0]  m_err_q;

	logic signed [OP_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	logic               s_fire, out_free;
	logic signed [33:0] m_w, e_w, e_dir_w;
	logic signed [31:0] err_w, mod_w, integ_add_w, integ_decay_w, sp_w;
	logic signed [49:0] prod_hi_w, lim_w;
	logic [15:0]        top_half_w;
	logic signed [31:0] top_w;
	logic [15:0]        period_w;

	assign period_w = 16'(PERIOD_CLOCKS);
	assign cfg_ready = 1'b1;
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;

	mcpl_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// datapath arithmetic
	always_comb begin
		m_w       = dir_last_q ? 34'(meas_q) : -34'(meas_q);
		e_w       = 34'(sp_q) - m_w;
		e_dir_w   = dir_now_q ? e_w : -e_w;
		err_w     = sat32(SAT_W'(e_dir_w));
		prod_hi_w = $signed(prod[PROD_W-1:16]);
		mod_w     = sat32(SAT_W'(prod_hi_w) + SAT_W'(integ_q));
		top_half_w = (max_mod_q > FULL_Q15) ? FULL_Q15 : max_mod_q;
		top_w     = $signed({15'b0, top_half_w, 1'b0});
		integ_add_w   = sat32(SAT_W'(integ_q) + SAT_W'(prod_hi_w));
		integ_decay_w = $signed(prod[47:16]);
		lim_w     = $signed({19'b0, curr_limit_q});
		if (prod_hi_w > lim_w) begin
			sp_w = $signed({1'b0, curr_limit_q});
		end else if (prod_hi_w < -lim_w) begin
			sp_w = -$signed({1'b0, curr_limit_q});
		end else begin
			sp_w = prod_hi_w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (req_type_q == REQ_SETPOINT && armed_q && req_tv_q &&
					req_vv_q && meas_valid_q) begin
					state_d = ST_SP_MUL;
				end else if (req_type_q == REQ_TICK && armed_q && meas_valid_q) begin
					state_d = ST_ERR;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SP_MUL: begin
				mul_a   = OP_W'(req_torque_q);
				mul_b   = $signed({2'b0, inv_torque_q});
				state_d = ST_SP;
			end
			ST_SP: state_d = ST_FIN;
			ST_ERR: state_d = ST_P_MUL;
			ST_P_MUL: begin
				mul_a   = $signed({2'b0, prop_gain_q});
				mul_b   = OP_W'(err_q);
				state_d = ST_MOD;
			end
			ST_MOD: state_d = mod_w[31] ? ST_W_MUL : ST_I_MUL;
			ST_I_MUL: begin
				if (clamp_hi_q) begin
					mul_a = OP_W'(integ_q);
					mul_b = DECAY_Q16;
				end else begin
					mul_a = $signed({2'b0, integ_gain_q});
					mul_b = OP_W'(err_q);
				end
				state_d = ST_INT;
			end
			ST_INT: state_d = ST_W_MUL;
			ST_W_MUL: begin
				mul_a   = $signed({17'b0, period_w});
				mul_b   = $signed({16'b0, mod_q[17:1]});
				state_d = ST_PWM;
			end
			ST_PWM: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			max_mod_q    <= MAX_MOD_RST;
			curr_limit_q <= CURR_LIMIT_RST;
			inv_torque_q <= INV_TORQUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[30:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[30:0];
				REG_MAX_MOD:    max_mod_q    <= cfg_data[15:0];
				REG_CURR_LIMIT: curr_limit_q <= cfg_data[30:0];
				REG_INV_TORQUE: inv_torque_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_type_q   <= s_axis_tuser;
			req_cur_q    <= $signed(s_axis_tdata[31:0]);
			req_cv_q     <= s_axis_tdata[32];
			req_torque_q <= $signed(s_axis_tdata[64:33]);
			req_tv_q     <= s_axis_tdata[65];
			req_vv_q     <= s_axis_tdata[66];
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			meas_valid_q <= 1'b0;
			dir_now_q    <= 1'b0;
			dir_last_q   <= 1'b0;
			meas_q       <= '0;
			sp_q         <= '0;
			integ_q      <= '0;
			fault_q      <= '0;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					unique case (req_type_q)
						REQ_ARM: armed_q <= 1'b1;
						REQ_DISARM: armed_q <= 1'b0;
						REQ_MEAS: begin
							meas_q       <= req_cur_q;
							meas_valid_q <= req_cv_q;
							if (!req_cv_q && armed_q) begin
								fault_q <= fault_q | FAULT_CURR;
								armed_q <= 1'b0;
							end
						end
						REQ_SETPOINT: begin
							if (armed_q) begin
								priority if (!req_tv_q) begin
									fault_q <= fault_q | FAULT_TORQUE;
									armed_q <= 1'b0;
								end else if (!req_vv_q) begin
									fault_q <= fault_q | FAULT_VEL;
									armed_q <= 1'b0;
								end else if (!meas_valid_q) begin
									fault_q <= fault_q | FAULT_CURR;
									armed_q <= 1'b0;
								end else begin
									dir_now_q <= !req_torque_q[31] && (req_torque_q != '0);
								end
							end
						end
						REQ_TICK: begin
							if (!(armed_q && meas_valid_q)) begin
								dir_last_q <= dir_now_q;
								if (armed_q) begin
									fault_q <= fault_q | FAULT_CURR;
									armed_q <= 1'b0;
								end
							end
						end
						default: ;
					endcase
				end
				ST_SP: sp_q <= sp_w;
				ST_INT: integ_q <= clamp_hi_q ? integ_decay_w : integ_add_w;
				ST_PWM: dir_last_q <= dir_now_q;
				default: ;
			endcase
		end
	end

	// tick working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EXEC: pwm_q <= '0;
			ST_ERR: err_q <= err_w;
			ST_MOD: begin
				clamp_hi_q <= mod_w > top_w;
				priority if (mod_w[31]) begin
					mod_q <= '0;
				end else if (mod_w > top_w) begin
					mod_q <= top_w;
				end else begin
					mod_q <= mod_w;
				end
			end
			ST_PWM: pwm_q <= prod[30:15];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_pwm_q <= pwm_q;
			m_dir_q <= dir_now_q;
			m_en_q  <= armed_q;
			m_err_q <= fault_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b0, m_err_q, m_en_q, m_dir_q, m_pwm_q};

endmodule
